/* hdl/framed_record_container_parser_assert.svh */
// Assertion macros shared by the parser RTL.
`ifndef FRAMED_RECORD_CONTAINER_PARSER_ASSERT_SVH
`define FRAMED_RECORD_CONTAINER_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define FCP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Condition must never hold.
`define FCP_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define FCP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define FCP_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

/* hdl/fcp_pkg.sv */
package fcp_pkg;

   // Queue between front and back; depth must be a power of two.
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QIdxW      = $clog2(QueueDepth);
   localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

   // Register reset values
   localparam logic [10:0] MaxFramesReset = 11'd1024;
   localparam logic [7:0]  MaxNameReset   = 8'd128;
   localparam logic [23:0] MaxTotalReset  = 24'd8388608;

   typedef enum logic [1:0] {
      REG_MAX_FRAMES = 2'd0,
      REG_MAX_NAME   = 2'd1,
      REG_MAX_TOTAL  = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_FRAME  = 2'd0,
      KIND_RECORD = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_OK         = 4'd0,
      ST_SHORT      = 4'd1,
      ST_OVERSIZE   = 4'd2,
      ST_FRAMES     = 4'd3,
      ST_TRUNCATED  = 4'd4,
      ST_NAME       = 4'd5,
      ST_OVERRUN    = 4'd6,
      ST_TERMINATOR = 4'd7,
      ST_TRAILING   = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      PH_COUNT = 3'd0,
      PH_NAME  = 3'd1,
      PH_PLEN  = 3'd2,
      PH_RLEN  = 3'd3,
      PH_RDATA = 3'd4,
      PH_DONE  = 3'd5,
      PH_ERR   = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  frame_number;
      logic [23:0] name_offset;
      logic [7:0]  name_length;
      logic [23:0] length_offset;
      logic [23:0] body_offset;
      logic [23:0] body_length;
      logic [3:0]  status_code;
   } rsp_beat_type;

   // Classified byte as it waits in the queue
   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
      logic       byte_zero;
   } qentry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Effective limits after clamping
   typedef struct packed {
      logic [10:0] frame_lim;
      logic [7:0]  name_lim;
      logic [23:0] size_lim;
   } limits_type;

endpackage

/* hdl/framed_record_container_parser.sv */
// Framed record container parser: takes one container byte per beat (last_byte marks the
// end) and sustains one byte per clock unless a stall holds it. A registered input stage
// classifies each byte and pushes it into a four-entry queue; the parse engine pops one
// byte per cycle, when it has one and the output is free, into a single output register;
// the queue lets input keep flowing while a result waits. Frame and record descriptors are
// provisional: a final status other than ok, given on the last byte, rejects all of them.
// The user must write limits through the register port between containers; unenforced.
`include "framed_record_container_parser_assert.svh"

module framed_record_container_parser
   import fcp_pkg::*;
#(
   parameter int unsigned CELL_LIMIT  = 8388608,
   parameter int unsigned FRAME_LIMIT = 1024,
   parameter int unsigned NAME_LIMIT  = 128
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_beat_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_beat_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [3:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam logic [24:0] CellLimitW  = 25'(CELL_LIMIT);
   localparam logic [16:0] FrameLimitW = 17'(FRAME_LIMIT);
   localparam logic [8:0]  NameLimitW  = 9'(NAME_LIMIT);

   logic [10:0]   max_frames_ff, max_frames_in;
   logic [7:0]    max_name_ff, max_name_in;
   logic [23:0]   max_total_ff, max_total_in;
   logic          csr_write;
   reg_index_type csr_index;
   limits_type    limits;
   logic          q_push, q_pop;
   qentry_type    q_push_data, q_pop_data;
   qstat_type     q_stat;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[3:2]);

   // Register writes
   always_comb begin
      max_frames_in = max_frames_ff;
      max_name_in   = max_name_ff;
      max_total_in  = max_total_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_MAX_FRAMES: max_frames_in = pwdata[10:0];
            REG_MAX_NAME:   max_name_in   = pwdata[7:0];
            REG_MAX_TOTAL:  max_total_in  = pwdata[23:0];
            default:        max_frames_in = max_frames_ff;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (csr_index)
         REG_MAX_FRAMES: prdata = {21'd0, max_frames_ff};
         REG_MAX_NAME:   prdata = {24'd0, max_name_ff};
         REG_MAX_TOTAL:  prdata = {8'd0, max_total_ff};
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frames_ff <= MaxFramesReset;
         max_name_ff   <= MaxNameReset;
         max_total_ff  <= MaxTotalReset;
      end else begin
         max_frames_ff <= max_frames_in;
         max_name_ff   <= max_name_in;
         max_total_ff  <= max_total_in;
      end
   end

   // Clamp each register to its build-time ceiling
   always_comb begin
      limits.size_lim  = ({1'b0, max_total_ff} < CellLimitW) ? max_total_ff
                                                             : CellLimitW[23:0];
      limits.frame_lim = ({6'd0, max_frames_ff} < FrameLimitW) ? max_frames_ff
                                                               : FrameLimitW[10:0];
      limits.name_lim  = ({1'b0, max_name_ff} < NameLimitW) ? max_name_ff
                                                            : NameLimitW[7:0];
   end

   fcp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .q_stat      (q_stat),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   fcp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .q_push      (q_push),
      .q_push_data (q_push_data),
      .q_pop       (q_pop),
      .q_pop_data  (q_pop_data),
      .q_stat      (q_stat)
   );

   fcp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .limits     (limits),
      .q_stat     (q_stat),
      .q_pop_data (q_pop_data),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   `FCP_ASSERT_NEVER(a_queue_full_empty, clock, reset, q_stat.full && q_stat.empty)
   `FCP_ASSERT_IMPLY(a_pop_nonempty, clock, reset, q_pop, !q_stat.empty)
   `FCP_ASSERT_IMPLY(a_pop_slot_free, clock, reset, q_pop, !rsp_valid || !rsp_stall)
   `FCP_ASSERT_IMPLY(a_push_room, clock, reset, q_push, !q_stat.full)

endmodule

/* hdl/fcp_front.sv */
module fcp_front
   import fcp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_beat_type req_data,
   input  qstat_type    q_stat,
   output logic         q_push,
   output qentry_type   q_push_data
);

   logic       front_valid_ff, front_valid_in;
   qentry_type front_data_ff, front_data_in;
   logic       accept;

   // Hold the beat while the queue is full
   assign q_push      = front_valid_ff && !q_stat.full;
   assign req_stall   = front_valid_ff && q_stat.full;
   assign q_push_data = front_data_ff;
   assign accept      = req_valid && !req_stall;

   // Capture and classify the incoming byte
   always_comb begin
      front_valid_in = accept || (front_valid_ff && q_stat.full);
      front_data_in  = front_data_ff;
      if (accept) begin
         front_data_in.byte_value = req_data.byte_value;
         front_data_in.last_byte  = req_data.last_byte;
         front_data_in.byte_zero  = (req_data.byte_value == 8'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_data_ff <= front_data_in;
   end

endmodule

/* hdl/fcp_queue.sv */
module fcp_queue
   import fcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_push,
   input  qentry_type q_push_data,
   input  logic       q_pop,
   output qentry_type q_pop_data,
   output qstat_type  q_stat
);

   qentry_type             mem [QueueDepth];
   logic [QIdxW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QIdxW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]       count_ff, count_in;

   assign q_pop_data   = mem[rd_ptr_ff];
   assign q_stat.full  = (count_ff == QCntW'(QueueDepth));
   assign q_stat.empty = (count_ff == '0);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = q_push ? wr_ptr_ff + QIdxW'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop  ? rd_ptr_ff + QIdxW'(1) : rd_ptr_ff;
      count_in  = count_ff + {{(QCntW-1){1'b0}}, q_push} - {{(QCntW-1){1'b0}}, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         mem[wr_ptr_ff] <= q_push_data;
      end
   end

endmodule

/* hdl/fcp_parser.sv */
module fcp_parser
   import fcp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  limits_type   limits,
   input  qstat_type    q_stat,
   input  qentry_type   q_pop_data,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_beat_type rsp_data
);

   phase_type    phase_ff, phase_in;
   status_type   err_ff, err_in;
   logic [23:0]  pos_ff, pos_in;
   logic [10:0]  frames_ff, frames_in;
   logic [10:0]  cur_ff, cur_in;
   logic [7:0]   ncount_ff, ncount_in;
   logic [23:0]  nstart_ff, nstart_in;
   logic [23:0]  wshift_ff, wshift_in;
   logic [1:0]   wcount_ff, wcount_in;
   logic [23:0]  wstart_ff, wstart_in;
   logic [23:0]  pleft_ff, pleft_in;
   logic [23:0]  rleft_ff, rleft_in;
   logic         out_valid_ff, out_valid_in;
   rsp_beat_type out_data_ff, out_data_in;

   logic         take;
   logic [7:0]   b;
   logic [31:0]  word;
   logic [23:0]  next_pos;
   logic         word_done;
   logic [23:0]  wshift_take;
   logic [1:0]   wcount_take;
   logic [23:0]  plen;
   logic [23:0]  pleft_dec;
   logic [23:0]  rleft_dec;
   logic [10:0]  cur_next;
   logic         emit;
   rsp_beat_type desc;

   // Pop one byte whenever the queue holds one and the output slot is free or draining
   assign take      = !q_stat.empty && (!out_valid_ff || !rsp_stall);
   assign q_pop     = take;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign b         = q_pop_data.byte_value;
   assign word      = {b, wshift_ff};
   assign next_pos  = pos_ff + 24'd1;
   assign word_done = (wcount_ff == 2'd3);
   assign plen      = (b != 8'd0) ? 24'hFFFFFF : word[23:0];
   assign pleft_dec = pleft_ff - 24'd1;
   assign rleft_dec = rleft_ff - 24'd1;
   assign cur_next  = cur_ff + 11'd1;

   // Place the byte into the little-endian length word
   always_comb begin
      wshift_take = wshift_ff;
      wcount_take = word_done ? wcount_ff : wcount_ff + 2'd1;
      unique case (wcount_ff)
         2'd0: wshift_take[7:0]   = b;
         2'd1: wshift_take[15:8]  = b;
         2'd2: wshift_take[23:16] = b;
         default: wshift_take     = wshift_ff;
      endcase
   end

   // Parse one byte, build a descriptor or the final status
   always_comb begin
      phase_in  = phase_ff;
      err_in    = err_ff;
      pos_in    = pos_ff;
      frames_in = frames_ff;
      cur_in    = cur_ff;
      ncount_in = ncount_ff;
      nstart_in = nstart_ff;
      wshift_in = wshift_ff;
      wcount_in = wcount_ff;
      wstart_in = wstart_ff;
      pleft_in  = pleft_ff;
      rleft_in  = rleft_ff;
      emit      = 1'b0;
      desc      = '0;

      if (take) begin
         if (phase_ff != PH_ERR) begin
            priority if (pos_ff >= limits.size_lim) begin
               err_in   = ST_OVERSIZE;
               phase_in = PH_ERR;
            end else begin
               pos_in = next_pos;
               unique case (phase_ff)
                  PH_COUNT: begin
                     wshift_in = wshift_take;
                     wcount_in = wcount_take;
                     if (word_done) begin
                        if (word > {21'd0, limits.frame_lim}) begin
                           err_in   = ST_FRAMES;
                           phase_in = PH_ERR;
                        end else begin
                           frames_in = word[10:0];
                           cur_in    = 11'd0;
                           if (word == 32'd0) begin
                              phase_in = PH_DONE;
                           end else begin
                              ncount_in = 8'd0;
                              nstart_in = next_pos;
                              phase_in  = PH_NAME;
                           end
                        end
                     end
                  end
                  PH_NAME: begin
                     priority if (q_pop_data.byte_zero) begin
                        if (ncount_ff == 8'd0) begin
                           err_in   = ST_NAME;
                           phase_in = PH_ERR;
                        end else begin
                           wshift_in = 24'd0;
                           wcount_in = 2'd0;
                           wstart_in = next_pos;
                           phase_in  = PH_PLEN;
                        end
                     end else if (ncount_ff >= limits.name_lim) begin
                        err_in   = ST_NAME;
                        phase_in = PH_ERR;
                     end else begin
                        ncount_in = ncount_ff + 8'd1;
                     end
                  end
                  PH_PLEN: begin
                     wshift_in = wshift_take;
                     wcount_in = wcount_take;
                     if (word_done) begin
                        pleft_in           = plen;
                        emit               = 1'b1;
                        desc.kind          = KIND_FRAME;
                        desc.frame_number  = cur_ff[9:0];
                        desc.name_offset   = nstart_ff;
                        desc.name_length   = ncount_ff;
                        desc.length_offset = wstart_ff;
                        desc.body_offset   = next_pos;
                        desc.body_length   = plen;
                        desc.status_code   = ST_OK;
                        // Flag a zero or too-short payload, else open the first record length word
                        priority if (plen == 24'd0) begin
                           err_in   = ST_TERMINATOR;
                           phase_in = PH_ERR;
                        end else if (plen < 24'd4) begin
                           err_in   = ST_OVERRUN;
                           phase_in = PH_ERR;
                        end else begin
                           wshift_in = 24'd0;
                           wcount_in = 2'd0;
                           wstart_in = next_pos;
                           phase_in  = PH_RLEN;
                        end
                     end
                  end
                  PH_RLEN: begin
                     pleft_in  = pleft_dec;
                     wshift_in = wshift_take;
                     wcount_in = wcount_take;
                     if (word_done) begin
                        priority if (word == 32'd0) begin
                           if (pleft_dec != 24'd0) begin
                              err_in   = ST_TERMINATOR;
                              phase_in = PH_ERR;
                           end else begin
                              cur_in = cur_next;
                              if (cur_next >= frames_ff) begin
                                 phase_in = PH_DONE;
                              end else begin
                                 ncount_in = 8'd0;
                                 nstart_in = next_pos;
                                 phase_in  = PH_NAME;
                              end
                           end
                        end else if (word > {8'd0, pleft_dec}) begin
                           err_in   = ST_OVERRUN;
                           phase_in = PH_ERR;
                        end else begin
                           emit               = 1'b1;
                           desc.kind          = KIND_RECORD;
                           desc.frame_number  = cur_ff[9:0];
                           desc.name_offset   = nstart_ff;
                           desc.name_length   = ncount_ff;
                           desc.length_offset = wstart_ff;
                           desc.body_offset   = next_pos;
                           desc.body_length   = word[23:0];
                           desc.status_code   = ST_OK;
                           rleft_in           = word[23:0];
                           phase_in           = PH_RDATA;
                        end
                     end
                  end
                  PH_RDATA: begin
                     rleft_in = rleft_dec;
                     pleft_in = pleft_dec;
                     if (rleft_dec == 24'd0) begin
                        priority if (pleft_dec == 24'd0) begin
                           err_in   = ST_TERMINATOR;
                           phase_in = PH_ERR;
                        end else if (pleft_dec < 24'd4) begin
                           err_in   = ST_OVERRUN;
                           phase_in = PH_ERR;
                        end else begin
                           wshift_in = 24'd0;
                           wcount_in = 2'd0;
                           wstart_in = next_pos;
                           phase_in  = PH_RLEN;
                        end
                     end
                  end
                  default: begin
                     // Any byte after the last frame
                     err_in   = ST_TRAILING;
                     phase_in = PH_ERR;
                  end
               endcase
            end
         end

         // Final byte: report status and return to the start state
         if (q_pop_data.last_byte) begin
            emit = 1'b1;
            desc = '0;
            desc.kind = KIND_STATUS;
            priority if (err_in != ST_OK) begin
               desc.status_code = err_in;
            end else if (pos_in < 24'd4) begin
               desc.status_code = ST_SHORT;
            end else if (phase_in != PH_DONE) begin
               desc.status_code = ST_TRUNCATED;
            end else begin
               desc.status_code = ST_OK;
            end
            phase_in  = PH_COUNT;
            err_in    = ST_OK;
            pos_in    = 24'd0;
            frames_in = 11'd0;
            cur_in    = 11'd0;
            ncount_in = 8'd0;
            nstart_in = 24'd0;
            wshift_in = 24'd0;
            wcount_in = 2'd0;
            wstart_in = 24'd0;
            pleft_in  = 24'd0;
            rleft_in  = 24'd0;
         end
      end
   end

   // Output slot: load on a new result, drop once taken
   always_comb begin
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (take && emit) begin
         out_valid_in = 1'b1;
         out_data_in  = desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COUNT;
         err_ff       <= ST_OK;
         pos_ff       <= 24'd0;
         frames_ff    <= 11'd0;
         cur_ff       <= 11'd0;
         ncount_ff    <= 8'd0;
         nstart_ff    <= 24'd0;
         wshift_ff    <= 24'd0;
         wcount_ff    <= 2'd0;
         wstart_ff    <= 24'd0;
         pleft_ff     <= 24'd0;
         rleft_ff     <= 24'd0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         err_ff       <= err_in;
         pos_ff       <= pos_in;
         frames_ff    <= frames_in;
         cur_ff       <= cur_in;
         ncount_ff    <= ncount_in;
         nstart_ff    <= nstart_in;
         wshift_ff    <= wshift_in;
         wcount_ff    <= wcount_in;
         wstart_ff    <= wstart_in;
         pleft_ff     <= pleft_in;
         rleft_ff     <= rleft_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
   end

endmodule
